// File: rtl/core/circular_onset_grid_remap_assert.svh
// ---------------------------------------------------------------------------
// circular_onset_grid_remap assertion macros
// Shared concurrent assertion forms for the grid remap checker.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_ONSET_GRID_REMAP_ASSERT_SVH
`define CIRCULAR_ONSET_GRID_REMAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define COGR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define COGR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cogr_pkg.sv
// ---------------------------------------------------------------------------
// cogr_pkg
// Shared widths, codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package cogr_pkg;

    localparam int STEP_W    = 7;   // step, onset and length counters
    localparam int PAT_W     = 64;  // result bitmap width
    localparam int PAT_IDX_W = 6;   // index into the result bitmap
    localparam int NUM_W     = 14;  // 2*q*M + N
    localparam int DEN_W     = 8;   // 2*N
    localparam int QUOT_W    = 7;   // new grid position, up to M
    localparam int DIV_CNT_W = 3;   // divider step counter
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_STEPS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_CLOCKWISE = 1'd1;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_TARGET = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LONG   = 2'd2;

    localparam logic [STEP_W-1:0] CNT_SAT = 7'd127;

    typedef struct packed {
        logic load;        // take one source step
        logic eval;        // latch status, start a remap pass
        logic scan_adv;    // move to the next source step
        logic div_start;   // launch a division for the current onset
        logic div_commit;  // place the divided onset and advance
        logic out_load;    // fill the output register, clear the source store
    } cogr_cmd_t;

    typedef struct packed {
        logic remap;       // pattern needs the divide pass
        logic scan_end;    // all source steps visited
        logic scan_onset;  // current source step holds an onset
        logic div_done;    // quotient ready
        logic out_free;    // output register can take a new item
    } cogr_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/cogr_div.sv
// ---------------------------------------------------------------------------
// cogr_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module cogr_div
    import cogr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    output logic                   done,
    output logic [QUOT_W-1:0]      quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     dsh_reg, dsh_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic                 fits;

    assign fits = rem_reg >= dsh_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(QUOT_W - 1);
            rem_next  = num;
            dsh_next  = {den, {(QUOT_W-1){1'b0}}};
            quot_next = '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            dsh_next  = {1'b0, dsh_reg[NUM_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: rtl/core/cogr_ctrl.sv
// ---------------------------------------------------------------------------
// cogr_ctrl
// Sequencer for load, evaluate, scan/divide and output phases.
// ---------------------------------------------------------------------------
`default_nettype none

module cogr_ctrl
    import cogr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    input  wire logic      s_tlast,
    output logic           s_tready,
    input  wire cogr_sts_t sts,
    output cogr_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_EVAL = 5'b00010,
        S_SCAN = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } cogr_state_t;

    cogr_state_t state_reg, state_next;

    assign s_tready = (state_reg == S_LOAD);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = sts.remap ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (sts.scan_end) begin
                    state_next = S_DONE;
                end else if (sts.scan_onset) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    cmd.scan_adv = 1'b1;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.div_commit = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/cogr_dp.sv
// ---------------------------------------------------------------------------
// cogr_dp
// Source store, counters, position math and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cogr_dp
    import cogr_pkg::*;
#(
    parameter int MAX_STEPS = 64,
    parameter int MIN_STEPS = 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic                 onset_bit,
    input  wire cogr_cmd_t            cmd,
    output cogr_sts_t                 sts,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [PAT_W-1:0]          new_pattern,
    output logic [STEP_W-1:0]         new_length,
    output logic [STEP_W-1:0]         source_length,
    output logic [STEP_W-1:0]         source_onsets,
    output logic [STEP_W-1:0]         kept_onsets,
    output logic [STAT_W-1:0]         status
);

    localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    logic [STEP_W-1:0]    target_reg;
    logic                 cw_reg;

    logic [MAX_STEPS-1:0] src_reg, src_next;
    logic [STEP_W-1:0]    step_cnt_reg, step_cnt_next;
    logic [STEP_W-1:0]    onset_cnt_reg, onset_cnt_next;
    logic                 ovf_reg, ovf_next;
    logic [STEP_W-1:0]    p_reg, p_next;
    logic [PAT_W-1:0]     pattern_reg, pattern_next;
    logic [STEP_W-1:0]    kept_reg, kept_next;
    logic [STAT_W-1:0]    st_reg, st_next;
    logic                 pass_reg, pass_next;

    logic                 m_valid_reg, m_valid_next;
    logic [PAT_W-1:0]     o_pattern_reg;
    logic [STEP_W-1:0]    o_newlen_reg, o_srclen_reg, o_srcons_reg, o_kept_reg;
    logic [STAT_W-1:0]    o_status_reg;

    logic [STAT_W-1:0]    eval_st;
    logic                 eval_pass;
    logic [STEP_W-1:0]    q;
    logic [2*STEP_W-1:0]  prod;
    logic [NUM_W-1:0]     div_num;
    logic [DEN_W-1:0]     div_den;
    logic                 div_done;
    logic [QUOT_W-1:0]    div_quot;
    logic [PAT_IDX_W-1:0] pos_idx;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= 7'd16;
            cw_reg     <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TARGET_STEPS:  target_reg <= cfg_wdata;
                REG_RUN_CLOCKWISE: cw_reg     <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Grid check, then length check.
    always_comb begin
        if (target_reg < STEP_W'(MIN_STEPS) || target_reg > STEP_W'(MAX_STEPS)) begin
            eval_st = ST_BAD_TARGET;
        end else if (ovf_reg) begin
            eval_st = ST_TOO_LONG;
        end else begin
            eval_st = ST_OK;
        end
    end
    assign eval_pass = (step_cnt_reg == target_reg);

    // Mirror index for counter-clockwise runs; numerator 2*q*M + N.
    assign q       = (cw_reg || p_reg == '0) ? p_reg : step_cnt_reg - p_reg;
    assign prod    = q * target_reg;
    assign div_num = {prod[NUM_W-2:0], 1'b0} + NUM_W'(step_cnt_reg);
    assign div_den = {step_cnt_reg, 1'b0};

    cogr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Wrap a position equal to M back to step zero.
    assign pos_idx = (div_quot >= target_reg) ? '0 : PAT_IDX_W'(div_quot);

    always_comb begin
        src_next       = src_reg;
        step_cnt_next  = step_cnt_reg;
        onset_cnt_next = onset_cnt_reg;
        ovf_next       = ovf_reg;
        p_next         = p_reg;
        pattern_next   = pattern_reg;
        kept_next      = kept_reg;
        st_next        = st_reg;
        pass_next      = pass_reg;

        if (cmd.load) begin
            if (step_cnt_reg >= STEP_W'(MAX_STEPS)) begin
                ovf_next = 1'b1;
            end else if (onset_bit) begin
                src_next[step_cnt_reg[IDX_W-1:0]] = 1'b1;
            end
            if (onset_bit && onset_cnt_reg != CNT_SAT) begin
                onset_cnt_next = onset_cnt_reg + 1'b1;
            end
            if (step_cnt_reg != CNT_SAT) begin
                step_cnt_next = step_cnt_reg + 1'b1;
            end
        end

        if (cmd.eval) begin
            st_next      = eval_st;
            pass_next    = eval_pass;
            p_next       = '0;
            pattern_next = '0;
            kept_next    = '0;
        end

        if (cmd.div_commit) begin
            pattern_next[pos_idx] = 1'b1;
            if (!pattern_reg[pos_idx]) begin
                kept_next = kept_reg + 1'b1;
            end
        end

        if (cmd.scan_adv || cmd.div_commit) begin
            src_next = {1'b0, src_reg[MAX_STEPS-1:1]};
            p_next   = p_reg + 1'b1;
        end

        if (cmd.out_load) begin
            src_next       = '0;
            step_cnt_next  = '0;
            onset_cnt_next = '0;
            ovf_next       = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg       <= '0;
            step_cnt_reg  <= '0;
            onset_cnt_reg <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            src_reg       <= src_next;
            step_cnt_reg  <= step_cnt_next;
            onset_cnt_reg <= onset_cnt_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
        end
        p_reg       <= p_next;
        pattern_reg <= pattern_next;
        kept_reg    <= kept_next;
        st_reg      <= st_next;
        pass_reg    <= pass_next;
    end

    // Output register: zeros on error, store as-is on equal grids.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_srclen_reg <= step_cnt_reg;
            o_srcons_reg <= onset_cnt_reg;
            o_status_reg <= st_reg;
            if (st_reg != ST_OK) begin
                o_pattern_reg <= '0;
                o_newlen_reg  <= '0;
                o_kept_reg    <= '0;
            end else if (pass_reg) begin
                o_pattern_reg <= PAT_W'(src_reg);
                o_newlen_reg  <= target_reg;
                o_kept_reg    <= onset_cnt_reg;
            end else begin
                o_pattern_reg <= pattern_reg;
                o_newlen_reg  <= target_reg;
                o_kept_reg    <= kept_reg;
            end
        end
    end

    assign sts.remap      = (eval_st == ST_OK) && !eval_pass;
    assign sts.scan_end   = (p_reg == step_cnt_reg);
    assign sts.scan_onset = src_reg[0];
    assign sts.div_done   = div_done;
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid      = m_valid_reg;
    assign new_pattern   = o_pattern_reg;
    assign new_length    = o_newlen_reg;
    assign source_length = o_srclen_reg;
    assign source_onsets = o_srcons_reg;
    assign kept_onsets   = o_kept_reg;
    assign status        = o_status_reg;

endmodule

`default_nettype wire

// File: rtl/core/circular_onset_grid_remap.sv
// ---------------------------------------------------------------------------
// circular_onset_grid_remap
// Remaps a circular onset pattern of N steps onto a grid of M steps.
// ---------------------------------------------------------------------------
// The block takes a pattern one step per item on the slave stream (onset in
// s_tdata[0], s_tlast on the final step) and returns one result item per
// pattern. Each onset at step p moves to round(q*M/N), q = p clockwise or
// (N-p) mod N counter-clockwise, ties upward, a result of M wrapping to 0;
// onsets landing together merge. Equal grids pass the pattern through.
// Sequence: one step per cycle while loading; after the last step the block
// evaluates, then scans the source steps; for each onset the serial
// restoring divider gives seven quotient bits and the onset is placed.
// When the scan closes, the result goes into the output register. A
// pass-through or an error result skips the scan.
// s_tready is low from the last step until the result is registered; the
// previous result may still wait on m_tready while the next pattern loads,
// and a result that is still waiting holds the block before its output
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_onset_grid_remap
    import cogr_pkg::*;
#(
    parameter int MAX_STEPS = 64,
    parameter int MIN_STEPS = 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
    // source steps
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [0] onset_bit, [7:1] zero
    input  wire logic                 s_tlast,   // last_step
    // results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [95:0]               m_tdata,   // [63:0] new_pattern,
                                                 // [70:64] new_length,
                                                 // [77:71] source_length,
                                                 // [84:78] source_onsets,
                                                 // [91:85] kept_onsets,
                                                 // [95:92] zero
    output logic [STAT_W-1:0]         m_tuser    // [1:0] status
);

    cogr_cmd_t         cmd;
    cogr_sts_t         sts;
    logic [PAT_W-1:0]  new_pattern;
    logic [STEP_W-1:0] new_length;
    logic [STEP_W-1:0] source_length;
    logic [STEP_W-1:0] source_onsets;
    logic [STEP_W-1:0] kept_onsets;

    // Sequence load, evaluate, scan/divide and output.
    cogr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the store, counters, divider and output register.
    cogr_dp #(
        .MAX_STEPS (MAX_STEPS),
        .MIN_STEPS (MIN_STEPS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .onset_bit     (s_tdata[0]),
        .cmd           (cmd),
        .sts           (sts),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .new_pattern   (new_pattern),
        .new_length    (new_length),
        .source_length (source_length),
        .source_onsets (source_onsets),
        .kept_onsets   (kept_onsets),
        .status        (m_tuser)
    );

    // Pack result fields, highest field first.
    assign m_tdata = {4'd0, kept_onsets, source_onsets, source_length,
                      new_length, new_pattern};

endmodule

`default_nettype wire

// File: rtl/core/cogr_checker.sv
// ---------------------------------------------------------------------------
// cogr_checker
// Port-level checks on the grid remap result stream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "circular_onset_grid_remap_assert.svh"

module cogr_checker
    import cogr_pkg::*;
#(
    parameter int MAX_STEPS = 64
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              s_tlast,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [95:0]       m_tdata,
    input wire logic [STAT_W-1:0] m_tuser
);

    // A stalled result holds.
    `COGR_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Error results carry no pattern, length or kept count.
    `COGR_ASSERT_SAME(a_err_zero, aclk, aresetn, m_tvalid && m_tuser != ST_OK, m_tdata[63:0] == 64'd0 && m_tdata[70:64] == 7'd0 && m_tdata[91:85] == 7'd0, "error result not zeroed")

    // Merging never adds onsets.
    `COGR_ASSERT_SAME(a_kept_le, aclk, aresetn, m_tvalid, m_tdata[91:85] <= m_tdata[84:78], "kept onsets exceed source onsets")

    // A good result comes from a pattern that fit the store.
    `COGR_ASSERT_SAME(a_ok_len, aclk, aresetn, m_tvalid && m_tuser == ST_OK, m_tdata[77:71] <= STEP_W'(MAX_STEPS) && m_tdata[70:64] != 7'd0, "good result with bad length")

    // Stop taking steps once a pattern is complete.
    `COGR_ASSERT_NEXT(a_last_stall, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready, "step taken right after last")

endmodule

bind circular_onset_grid_remap cogr_checker #(
    .MAX_STEPS (MAX_STEPS)
) u_cogr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
